// ===== sv/rbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsm_pkg
// Shared types, command and status codes for the ring buffer space manager.
// ----------------------------------------------------------------------------
package rbsm_pkg;

   localparam int IDX_W = 16;
   localparam int CAP_W = IDX_W + 1;

   localparam longint unsigned DEFAULT_RING_SLOTS = 64'd65536;

   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_PEEK    = 2'd1;
   localparam logic [1:0] CMD_CONSUME = 2'd2;
   localparam logic [1:0] CMD_LOCATE  = 2'd3;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_SPACE    = 2'd1;
   localparam logic [1:0] ST_BEYOND_FILL = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [IDX_W-1:0] byte_count;
      logic [IDX_W-1:0] offset;
      logic [IDX_W-1:0] storage_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] first_start;
      logic [IDX_W-1:0] first_length;
      logic [IDX_W-1:0] second_length;
      logic [IDX_W-1:0] position;
      logic [IDX_W-1:0] fill_level;
   } rsp_type;

endpackage

// ===== sv/rbsm_in_stage.sv =====
// ----------------------------------------------------------------------------
// rbsm_in_stage
// Input register: captures one command item and holds it until the engine
// hands its result to the output register.
// ----------------------------------------------------------------------------
module rbsm_in_stage
   import rbsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    take;

   assign req_stall  = valid_ff && !advance;
   assign take       = req_valid && !req_stall;
   assign valid_in   = take || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== sv/rbsm_engine.sv =====
// ----------------------------------------------------------------------------
// rbsm_engine
// Ring bookkeeping: write index, read index, held bytes and size register,
// plus the single-pass placement logic for one command.
// ----------------------------------------------------------------------------
module rbsm_engine
   import rbsm_pkg::*;
#(
   parameter longint unsigned MAX_RING_SLOTS = DEFAULT_RING_SLOTS
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   input  logic             fire,
   input  req_type          item,
   output rsp_type          result
);

   localparam longint unsigned FULL_SLOTS = 64'd1 << IDX_W;
   localparam logic [CAP_W-1:0] CAP_LIMIT =
      CAP_W'((MAX_RING_SLOTS > FULL_SLOTS) ? FULL_SLOTS : MAX_RING_SLOTS);

   logic [IDX_W-1:0] max_size_ff;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [IDX_W-1:0] held_ff, held_in;

   logic [CAP_W-1:0] cap_raw;
   logic [CAP_W-1:0] cap;
   logic [IDX_W-1:0] usable;
   logic [IDX_W-1:0] spare_bytes;
   logic [IDX_W-1:0] peek_start;
   logic [IDX_W-1:0] place_start;
   logic [CAP_W-1:0] room;
   logic [IDX_W-1:0] seg1;
   logic [IDX_W-1:0] seg2;
   logic [IDX_W-1:0] write_adv;
   logic [IDX_W-1:0] read_adv;
   logic [CAP_W-1:0] peek_end;

   function automatic logic [IDX_W-1:0] wrap_add(
      input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] b,
      input logic [CAP_W-1:0] c
   );
      logic [CAP_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= c) begin
         s = s - c;
      end
      return s[IDX_W-1:0];
   endfunction

   assign cap_raw    = {1'b0, max_size_ff} + CAP_W'(1);
   assign cap        = (cap_raw > CAP_LIMIT) ? CAP_LIMIT : cap_raw;
   assign usable     = IDX_W'(cap - CAP_W'(1));
   assign spare_bytes = usable - held_ff;
   assign peek_start = wrap_add(read_index_ff, item.offset, cap);
   assign place_start = (item.command == CMD_RESERVE) ? write_index_ff : peek_start;
   assign room       = cap - {1'b0, place_start};
   assign seg1       = ({1'b0, item.byte_count} < room) ? item.byte_count
                                                         : room[IDX_W-1:0];
   assign seg2       = item.byte_count - seg1;
   assign write_adv  = wrap_add(write_index_ff, item.byte_count, cap);
   assign read_adv   = wrap_add(read_index_ff, item.byte_count, cap);
   assign peek_end   = {1'b0, item.offset} + {1'b0, item.byte_count};

   always_comb begin
      write_index_in       = write_index_ff;
      read_index_in        = read_index_ff;
      held_in              = held_ff;
      result               = '0;
      case (item.command)
         CMD_RESERVE: begin
            if (item.byte_count > spare_bytes) begin
               result.status = ST_NO_SPACE;
            end else begin
               result.first_start   = place_start;
               result.first_length  = seg1;
               result.second_length = seg2;
               write_index_in       = write_adv;
               held_in              = held_ff + item.byte_count;
            end
         end
         CMD_PEEK: begin
            if (peek_end > {1'b0, held_ff}) begin
               result.status = ST_BEYOND_FILL;
            end else begin
               result.first_start   = place_start;
               result.first_length  = seg1;
               result.second_length = seg2;
            end
         end
         CMD_CONSUME: begin
            if (item.byte_count > held_ff) begin
               result.status = ST_BEYOND_FILL;
            end else begin
               read_index_in = read_adv;
               held_in       = held_ff - item.byte_count;
            end
         end
         CMD_LOCATE: begin
            if ({1'b0, item.storage_index} >= cap) begin
               result.status = ST_BEYOND_FILL;
            end else if (item.storage_index >= read_index_ff) begin
               result.position = item.storage_index - read_index_ff;
            end else begin
               result.position = IDX_W'(cap - {1'b0, read_index_ff}
                                        + {1'b0, item.storage_index});
            end
         end
         default: begin
            result.status = ST_BEYOND_FILL;
         end
      endcase
      result.fill_level = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff    <= '1;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         held_ff        <= '0;
      end else if (csr_wr_en) begin
         max_size_ff    <= csr_wr_data;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         held_ff        <= '0;
      end else if (fire) begin
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         held_ff        <= held_in;
      end
   end

   a_held_fits: assert property (@(posedge clock) disable iff (reset)
      held_ff <= usable)
      else $error("held bytes exceed usable space");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, write_index_ff} < cap) && ({1'b0, read_index_ff} < cap))
      else $error("ring index out of range");

   a_index_gap: assert property (@(posedge clock) disable iff (reset)
      (write_index_ff >= read_index_ff) ?
         ((write_index_ff - read_index_ff) == held_ff) :
         (IDX_W'(cap - {1'b0, read_index_ff} + {1'b0, write_index_ff}) == held_ff))
      else $error("index gap disagrees with held bytes");

   a_refused_keeps: assert property (@(posedge clock) disable iff (reset)
      (fire && !csr_wr_en && (result.status != ST_OK)) |=>
         ($stable(held_ff) && $stable(write_index_ff) && $stable(read_index_ff)))
      else $error("refused command changed ring state");

endmodule

// ===== sv/rbsm_out_stage.sv =====
// ----------------------------------------------------------------------------
// rbsm_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module rbsm_out_stage
   import rbsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    item_valid,
   input  rsp_type result,
   output logic    advance,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign advance   = !valid_ff || !rsp_stall;
   assign valid_in  = advance ? item_valid : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid) begin
         rsp_ff <= result;
      end
   end

endmodule

// ===== sv/ring_buffer_space_manager_top.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_space_manager_top
// Space bookkeeping for a byte ring of max size + 1 slots: reserve, peek,
// consume and locate commands, one result item per command.
// ----------------------------------------------------------------------------
//   port group  direction  handshake            payload
//   req_*       in         req_valid/req_stall  command, byte_count, offset,
//                                               storage_index
//   rsp_*       out        rsp_valid/rsp_stall  status, first_start, first_length,
//                                               second_length, position, fill_level
//   csr_*       in         csr_wr_en            max size in bytes
//
// One item per cycle unless rsp_stall holds the flow; results are registered.
// Throughput is set by the single-pass command logic between the input
// register and the result register, which also updates the ring indices.
// Synchronous reset empties the ring and sets the size to 65535.
// A stalled result holds the result register; one more item waits in the
// input register, after which req_stall rises.
// ----------------------------------------------------------------------------
module ring_buffer_space_manager_top
   import rbsm_pkg::*;
#(
   parameter longint unsigned MAX_RING_SLOTS = DEFAULT_RING_SLOTS
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_command,
   input  logic [IDX_W-1:0] req_byte_count,
   input  logic [IDX_W-1:0] req_offset,
   input  logic [IDX_W-1:0] req_storage_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [IDX_W-1:0] rsp_first_start,
   output logic [IDX_W-1:0] rsp_first_length,
   output logic [IDX_W-1:0] rsp_second_length,
   output logic [IDX_W-1:0] rsp_position,
   output logic [IDX_W-1:0] rsp_fill_level
);

   req_type req_item;
   req_type item;
   logic    item_valid;
   logic    advance;
   rsp_type result;
   rsp_type rsp_item;

   assign req_item.command       = req_command;
   assign req_item.byte_count    = req_byte_count;
   assign req_item.offset        = req_offset;
   assign req_item.storage_index = req_storage_index;

   rbsm_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rbsm_engine #(
      .MAX_RING_SLOTS (MAX_RING_SLOTS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (item_valid && advance),
      .item        (item),
      .result      (result)
   );

   rbsm_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_status        = rsp_item.status;
   assign rsp_first_start   = rsp_item.first_start;
   assign rsp_first_length  = rsp_item.first_length;
   assign rsp_second_length = rsp_item.second_length;
   assign rsp_position      = rsp_item.position;
   assign rsp_fill_level    = rsp_item.fill_level;

endmodule

// ===== sim/ring_buffer_space_manager_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_space_manager_checker
// Watches the size register port and both item channels of the ring buffer
// space manager. Keeps its own copy of the ring indices and fill count,
// works out the result of every accepted command and compares each accepted
// result item, field by field, against the oldest one still pending.
// ----------------------------------------------------------------------------
module ring_buffer_space_manager_checker
   import rbsm_pkg::*;
#(
   parameter longint unsigned MAX_RING_SLOTS = DEFAULT_RING_SLOTS
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [1:0]       req_command,
   input  logic [IDX_W-1:0] req_byte_count,
   input  logic [IDX_W-1:0] req_offset,
   input  logic [IDX_W-1:0] req_storage_index,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [1:0]       rsp_status,
   input  logic [IDX_W-1:0] rsp_first_start,
   input  logic [IDX_W-1:0] rsp_first_length,
   input  logic [IDX_W-1:0] rsp_second_length,
   input  logic [IDX_W-1:0] rsp_position,
   input  logic [IDX_W-1:0] rsp_fill_level,
   output int unsigned      mismatches,
   output int unsigned      outstanding
);

   logic [IDX_W-1:0] size_reg;
   logic [IDX_W-1:0] write_ptr;
   logic [IDX_W-1:0] read_ptr;
   logic [IDX_W-1:0] held_count;
   rsp_type          pending_results[$];
   rsp_type          oldest;
   int unsigned      fail_total;

   function automatic longint unsigned ring_slots();
      longint unsigned slots;
      slots = {48'd0, size_reg} + 64'd1;
      if (slots > MAX_RING_SLOTS) begin
         slots = MAX_RING_SLOTS;
      end
      return slots;
   endfunction

   function automatic longint unsigned ring_add(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned slots);
      longint unsigned sum;
      sum = a + b;
      if (sum >= slots) begin
         sum = sum - slots;
      end
      return sum;
   endfunction

   function automatic void set_placement(inout rsp_type r,
                                         input longint unsigned start,
                                         input longint unsigned count,
                                         input longint unsigned slots);
      longint unsigned room;
      longint unsigned head;
      room = slots - start;
      head = (count < room) ? count : room;
      r.first_start   = IDX_W'(start);
      r.first_length  = IDX_W'(head);
      r.second_length = IDX_W'(count - head);
   endfunction

   function automatic rsp_type apply_command(input logic [1:0]       cmd,
                                             input logic [IDX_W-1:0] count_in,
                                             input logic [IDX_W-1:0] offset_in,
                                             input logic [IDX_W-1:0] slot_in);
      rsp_type         r;
      longint unsigned slots;
      longint unsigned usable;
      longint unsigned room;
      longint unsigned count;
      longint unsigned peek_off;
      longint unsigned slot;
      longint unsigned held;
      longint unsigned rd;
      r        = '0;
      slots    = ring_slots();
      usable   = slots - 1;
      count    = count_in;
      peek_off = offset_in;
      slot     = slot_in;
      held     = held_count;
      rd       = read_ptr;
      case (cmd)
         CMD_RESERVE: begin
            room = (held <= usable) ? usable - held : 64'd0;
            if (count > room) begin
               r.status = ST_NO_SPACE;
            end else begin
               set_placement(r, write_ptr, count, slots);
               write_ptr  = IDX_W'(ring_add(write_ptr, count, slots));
               held_count = IDX_W'(held + count);
            end
         end
         CMD_PEEK: begin
            if (peek_off + count > held) begin
               r.status = ST_BEYOND_FILL;
            end else begin
               set_placement(r, ring_add(rd, peek_off, slots), count, slots);
            end
         end
         CMD_CONSUME: begin
            if (count > held) begin
               r.status = ST_BEYOND_FILL;
            end else begin
               read_ptr   = IDX_W'(ring_add(rd, count, slots));
               held_count = IDX_W'(held - count);
            end
         end
         CMD_LOCATE: begin
            if (slot >= slots) begin
               r.status = ST_BEYOND_FILL;
            end else if (slot >= rd) begin
               r.position = IDX_W'(slot - rd);
            end else begin
               r.position = IDX_W'(slots - rd + slot);
            end
         end
         default: begin
            r.status = ST_BEYOND_FILL;
         end
      endcase
      r.fill_level = held_count;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [IDX_W-1:0] want,
                                input logic [IDX_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         size_reg   = '1;
         write_ptr  = '0;
         read_ptr   = '0;
         held_count = '0;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            size_reg   = csr_wr_data;
            write_ptr  = '0;
            read_ptr   = '0;
            held_count = '0;
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(apply_command(req_command, req_byte_count,
                                                    req_offset, req_storage_index));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result item arrived with no command pending");
               fail_total++;
            end else begin
               oldest = pending_results.pop_front();
               compare_field("status", IDX_W'(oldest.status), IDX_W'(rsp_status));
               compare_field("first_start", oldest.first_start, rsp_first_start);
               compare_field("first_length", oldest.first_length, rsp_first_length);
               compare_field("second_length", oldest.second_length, rsp_second_length);
               compare_field("position", oldest.position, rsp_position);
               compare_field("fill_level", oldest.fill_level, rsp_fill_level);
            end
         end
      end
      mismatches  <= fail_total;
      outstanding <= pending_results.size();
   end

endmodule

// ===== sim/tb_ring_buffer_space_manager_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_space_manager_top
// Drives reserve, peek, consume and locate commands into the ring buffer
// space manager under a range of ring sizes: a directed pass over the edge
// cases, then random traffic with idle bursts, a long result hold-off and a
// quiet tail. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_ring_buffer_space_manager_top;
   import rbsm_pkg::*;

   localparam longint unsigned RING_SLOTS   = DEFAULT_RING_SLOTS;
   localparam int              PHASES       = 8;
   localparam int              PHASE_ITEMS  = 230;
   localparam int              LONG_HOLD    = 80;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [IDX_W-1:0] csr_wr_data;
   logic             req_valid;
   logic             req_stall;
   logic [1:0]       req_command;
   logic [IDX_W-1:0] req_byte_count;
   logic [IDX_W-1:0] req_offset;
   logic [IDX_W-1:0] req_storage_index;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [1:0]       rsp_status;
   logic [IDX_W-1:0] rsp_first_start;
   logic [IDX_W-1:0] rsp_first_length;
   logic [IDX_W-1:0] rsp_second_length;
   logic [IDX_W-1:0] rsp_position;
   logic [IDX_W-1:0] rsp_fill_level;
   int unsigned      mismatches;
   int unsigned      outstanding;
   bit               hold_request = 1'b0;
   bit               quiet_tail   = 1'b0;

   ring_buffer_space_manager_top #(
      .MAX_RING_SLOTS(RING_SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_byte_count   (req_byte_count),
      .req_offset       (req_offset),
      .req_storage_index(req_storage_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_first_start  (rsp_first_start),
      .rsp_first_length (rsp_first_length),
      .rsp_second_length(rsp_second_length),
      .rsp_position     (rsp_position),
      .rsp_fill_level   (rsp_fill_level)
   );

   ring_buffer_space_manager_checker #(
      .MAX_RING_SLOTS(RING_SLOTS)
   ) result_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_byte_count   (req_byte_count),
      .req_offset       (req_offset),
      .req_storage_index(req_storage_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_first_start  (rsp_first_start),
      .rsp_first_length (rsp_first_length),
      .rsp_second_length(rsp_second_length),
      .rsp_position     (rsp_position),
      .rsp_fill_level   (rsp_fill_level),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // offer one item and hold it until it is taken
   task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] count,
                            input logic [IDX_W-1:0] off, input logic [IDX_W-1:0] slot);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_byte_count    <= count;
      req_offset        <= off;
      req_storage_index <= slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(input logic [IDX_W-1:0] size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(input int unsigned size);
      int unsigned      span;
      logic [1:0]       cmd;
      logic [IDX_W-1:0] count;
      logic [IDX_W-1:0] off;
      logic [IDX_W-1:0] slot;
      span = size / 2 + 1;
      if ($urandom_range(0, 99) < 10) begin
         cmd   = 2'($urandom);
         count = IDX_W'($urandom);
         off   = IDX_W'($urandom);
         slot  = IDX_W'($urandom);
      end else begin
         cmd   = 2'($urandom_range(0, 3));
         count = IDX_W'($urandom_range(0, span));
         off   = IDX_W'($urandom_range(0, span / 2));
         slot  = IDX_W'($urandom_range(0, size + 1));
         if (cmd == CMD_PEEK) begin
            count = count >> 1;
         end
      end
      send_item(cmd, count, off, slot);
   endtask

   task automatic run_directed();
      send_item(CMD_LOCATE,  16'd0,     16'd0,     16'd0);
      send_item(CMD_LOCATE,  16'd0,     16'd0,     16'hFFFF);
      send_item(CMD_PEEK,    16'd0,     16'd0,     16'd0);
      send_item(CMD_PEEK,    16'd1,     16'd0,     16'd0);
      send_item(CMD_CONSUME, 16'd0,     16'd0,     16'd0);
      send_item(CMD_CONSUME, 16'd1,     16'd0,     16'd0);
      send_item(CMD_RESERVE, 16'd0,     16'd0,     16'd0);
      send_item(CMD_RESERVE, 16'hFFFF,  16'd0,     16'd0);
      send_item(CMD_RESERVE, 16'd1,     16'd0,     16'd0);
      send_item(CMD_PEEK,    16'd0,     16'hFFFF,  16'd0);
      send_item(CMD_PEEK,    16'hFFFF,  16'd1,     16'd0);
      send_item(CMD_PEEK,    16'hFFFF,  16'd0,     16'd0);
      send_item(CMD_CONSUME, 16'hFFFF,  16'd0,     16'd0);
      send_item(CMD_RESERVE, 16'd10,    16'd0,     16'd0);
      send_item(CMD_LOCATE,  16'd0,     16'd0,     16'd0);
      send_item(CMD_PEEK,    16'd8,     16'd2,     16'd0);
      send_item(CMD_CONSUME, 16'd10,    16'd0,     16'd0);
      wait_idle();
      write_size(16'd0);
      send_item(CMD_RESERVE, 16'd0,     16'd0,     16'd0);
      send_item(CMD_RESERVE, 16'd1,     16'd0,     16'd0);
      send_item(CMD_LOCATE,  16'd0,     16'd0,     16'd0);
      send_item(CMD_LOCATE,  16'd0,     16'd0,     16'd1);
      send_item(CMD_PEEK,    16'd0,     16'd0,     16'd0);
      wait_idle();
      write_size(16'd5);
      send_item(CMD_RESERVE, 16'd4,     16'd0,     16'd0);
      send_item(CMD_CONSUME, 16'd3,     16'd0,     16'd0);
      send_item(CMD_RESERVE, 16'd4,     16'd0,     16'd0);
      send_item(CMD_LOCATE,  16'd0,     16'd0,     16'd2);
   endtask

   initial begin : result_side
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [IDX_W-1:0] phase_size [PHASES];
      int               p;
      int               i;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_valid         <= 1'b0;
      req_command       <= CMD_RESERVE;
      req_byte_count    <= '0;
      req_offset        <= '0;
      req_storage_index <= '0;
      phase_size[0] = 16'd1;
      phase_size[1] = 16'd0;
      phase_size[2] = 16'd7;
      phase_size[3] = IDX_W'($urandom_range(2, 64));
      phase_size[4] = 16'hFFFF;
      phase_size[5] = 16'hFFFE;
      phase_size[6] = IDX_W'($urandom_range(100, 2000));
      phase_size[7] = 16'd3;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      run_directed();
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         write_size(phase_size[p]);
         if (p == PHASES - 1) begin
            quiet_tail = 1'b1;
         end
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 60) begin
               hold_request = 1'b1;
            end
            if (p == 4 && i == 100) begin
               wait_idle();
            end
            send_random(phase_size[p]);
            if (!quiet_tail && $urandom_range(0, 4) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 7)) @(posedge clock);
            end
         end
      end
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
